### src/osd_smc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osd_smc_pkg
// Shared constants and field tables for the OSD settings menu controller.
// ----------------------------------------------------------------------------
package osd_smc_pkg;

	localparam int KeyW  = 8;
	localparam int WordW = 16;
	localparam int RowW  = 3;

	localparam int KEY_F11   = 7;
	localparam int KEY_F3    = 6;
	localparam int KEY_RIGHT = 5;
	localparam int KEY_LEFT  = 4;
	localparam int KEY_DOWN  = 3;
	localparam int KEY_UP    = 2;

	localparam int BIT_ENABLE = 15;
	localparam int BIT_RESET  = 11;

	localparam logic [WordW-1:0] SETTINGS_RESET = 16'h000C;
	localparam logic [RowW-1:0]  LAST_ROW       = 3'd5;

	typedef logic [RowW-1:0] row_t;

	// bit position of the low end of each row's field
	function automatic logic [3:0] field_lsb(input row_t r);
		logic [3:0] v;
		case (r)
			3'd0:    v = 4'd7;
			3'd1:    v = 4'd6;
			3'd2:    v = 4'd5;
			3'd3:    v = 4'd4;
			3'd4:    v = 4'd2;
			default: v = 4'd0;
		endcase
		return v;
	endfunction

	// largest value each row's field may hold
	function automatic logic [1:0] field_max(input row_t r);
		logic [1:0] v;
		case (r)
			3'd0, 3'd1, 3'd2, 3'd3: v = 2'd1;
			default:                v = 2'd3;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### src/osd_settings_menu_controller.sv
// One polled key byte per beat in, one result beat out: the control word, the
// selected menu row and a redraw flag. A beat can be taken every clock cycle
// while in_stall is low; each beat passes through the input register and then
// the result register, and leaves the result register when the output is not
// stalled. The settings, the row and the previous key byte update once per
// beat as it moves from the input register into the result register.
`default_nettype none
// ----------------------------------------------------------------------------
// osd_settings_menu_controller
// Key edge detection, menu navigation and settings field adjustment.
// ----------------------------------------------------------------------------
module osd_settings_menu_controller
	import osd_smc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [KeyW-1:0]  keys,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [WordW-1:0]      control_word,
	output logic [RowW-1:0]       menu_row,
	output logic                  redraw
);

	logic             valid_s1;
	logic [KeyW-1:0]  keys_s1;
	logic             valid_s2;
	logic [WordW-1:0] word_s2;
	row_t             row_s2;
	logic             redraw_s2;

	logic [WordW-1:0] settings_q;
	row_t             row_q;
	logic [KeyW-1:0]  prev_keys_q;

	logic             s2_free;
	logic             advance;
	logic             accept;

	logic [KeyW-1:0]  rise;
	row_t             row_cur;
	row_t             row_up;
	row_t             row_nx;
	logic [WordW-1:0] set_tog;
	logic [WordW-1:0] set_nx;
	logic [WordW-1:0] mask;
	logic [3:0]       lsb;
	logic [1:0]       top;
	logic [1:0]       val;
	logic [WordW-1:0] word_nx;

	// handshake
	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	// per-beat work
	always_comb begin
		rise    = keys_s1 & ~prev_keys_q;
		row_cur = (row_q > LAST_ROW) ? LAST_ROW : row_q;
		set_tog = settings_q;
		if (rise[KEY_F11]) begin
			set_tog[BIT_ENABLE] = ~settings_q[BIT_ENABLE];
		end
		row_up = row_cur;
		if (rise[KEY_UP] && row_cur != 3'd0) begin
			row_up = row_cur - 3'd1;
		end
		row_nx = row_up;
		if (rise[KEY_DOWN] && row_up < LAST_ROW) begin
			row_nx = row_up + 3'd1;
		end
		lsb  = field_lsb(row_nx);
		top  = field_max(row_nx);
		mask = WordW'({14'd0, top} << lsb);
		val  = 2'((set_tog & mask) >> lsb);
		set_nx = set_tog;
		if (rise[KEY_LEFT]) begin
			if (val != 2'd0) begin
				set_nx = (set_tog & ~mask) | ((WordW'(val - 2'd1) << lsb) & mask);
			end
		end else if (rise[KEY_RIGHT]) begin
			if (val != top) begin
				set_nx = (set_tog & ~mask) | ((WordW'(val + 2'd1) << lsb) & mask);
			end
		end
		word_nx = set_nx;
		word_nx[BIT_RESET] = set_nx[BIT_ENABLE] && keys_s1[KEY_F3];
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			keys_s1 <= keys;
		end
	end

	// state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings_q  <= SETTINGS_RESET;
			row_q       <= '0;
			prev_keys_q <= '0;
		end else if (advance) begin
			settings_q  <= set_nx;
			row_q       <= row_nx;
			prev_keys_q <= keys_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2   <= word_nx;
			row_s2    <= row_nx;
			redraw_s2 <= (keys_s1 != prev_keys_q);
		end
	end

	assign out_valid    = valid_s2;
	assign control_word = word_s2;
	assign menu_row     = row_s2;
	assign redraw       = redraw_s2;

	// checks
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (menu_row <= LAST_ROW))
		else $error("menu row out of range");

	a_reset_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && control_word[BIT_RESET] |-> control_word[BIT_ENABLE])
		else $error("reset bit without enable");

	a_unused_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (control_word[14:12] == 3'd0 && control_word[10:8] == 3'd0))
		else $error("unused control bits set");

	a_state_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= LAST_ROW)
		else $error("stored row out of range");

endmodule
`default_nettype wire
